// ===== design/htw_pkg.sv =====
// Shared types and constants for the hierarchical timer wheel.
// No dependencies; imported by the front, back and top level.
package htw_pkg;

  localparam int MODE_W      = 2;
  localparam int TO_W        = 32;
  localparam int HND_W       = 16;
  localparam int IV_W        = 16;
  localparam int ST_W        = 2;
  localparam int MAX_RESULTS = 64;
  localparam logic [IV_W-1:0] IV_RESET = 16'd1000;

  typedef enum logic [MODE_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NOP  = 2'd3
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_ENTRY  = 2'd2,
    ST_BEYOND    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [4:0] {
    B_CLR,
    B_IDLE,
    B_RES,
    A_SCAN,
    A_LINK,
    D_SCAN,
    D_CHK,
    D_HEAD,
    D_WALK,
    D_STEP,
    T_ADV,
    T_NEXT,
    T_CHEAD,
    T_CWALK,
    T_CREAD,
    T_CLINK,
    T_EXP0,
    T_EHEAD,
    T_EWALK,
    T_EOUT
  } back_state_e;

  typedef struct packed {
    logic init_done;
    logic busy;
  } back_stat_t;

endpackage

// ===== design/htw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module htw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/htw_queue.sv =====
// Two-entry command queue between front and back.
// No dependencies.
module htw_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] buf_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = buf_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // hold the stored beats
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wptr_q] <= push_data_i;
  end

endmodule

// ===== design/htw_front.sv =====
// Front end: accepts input beats, classifies them and turns an add timeout
// into per-level tick digits with a bit-serial divider. Uses htw_pkg.
module htw_front #(
  parameter int LEVELS = 4,
  parameter int SLOTS  = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [htw_pkg::MODE_W-1:0]  mode_i,
  input  logic [htw_pkg::TO_W-1:0]    timeout_i,
  input  logic [htw_pkg::HND_W-1:0]   target_i,
  input  logic [htw_pkg::IV_W-1:0]    interval_i,
  input  htw_pkg::back_stat_t         bstat_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output logic [htw_pkg::MODE_W+LEVELS*$clog2(SLOTS)+1+htw_pkg::HND_W-1:0] push_data_o
);
  import htw_pkg::*;

  localparam int DW  = $clog2(SLOTS);
  localparam int XW  = LEVELS * DW;
  localparam int BW  = $clog2(TO_W);

  front_state_e state_q, state_d;
  cmd_e                       mode_q;
  logic [HND_W-1:0]           tgt_q;
  logic [TO_W-1:0]            dvd_q, dvd_d;
  logic [IV_W-1:0]            rem_q, rem_d;
  logic [IV_W-1:0]            div_q, div_d;
  logic [BW-1:0]              bit_q, bit_d;
  logic [LEVELS-1:0][DW-1:0]  dig_q, dig_d;
  logic                       big_q, big_d;
  logic                       accept;
  logic [IV_W:0]              rs, rsub;
  logic                       ge;
  logic [TO_W-1:0]            qf;
  logic [IV_W-1:0]            rf;
  logic [TO_W-1:0]            delta;
  logic [XW+TO_W-1:0]         dext;

  assign in_ready_o   = (state_q == F_IDLE) && bstat_i.init_done;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = (state_q == F_PUSH);
  assign push_data_o  = {mode_q, dig_q, big_q, tgt_q};

  // one restoring division step
  assign rs   = {rem_q, dvd_q[TO_W-1]};
  assign ge   = (rs >= {1'b0, div_q});
  assign rsub = rs - {1'b0, div_q};
  assign rf   = ge ? rsub[IV_W-1:0] : rs[IV_W-1:0];
  assign qf   = {dvd_q[TO_W-2:0], ge};

  // delta of at least one tick; SLOTS is a power of two, so digits are slices
  assign delta = (qf == '0) ? TO_W'(1) : qf;
  assign dext  = {{XW{1'b0}}, delta};

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= cmd_e'(mode_i);
      tgt_q  <= target_i;
    end
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    div_q <= div_d;
    bit_q <= bit_d;
    dig_q <= dig_d;
    big_q <= big_d;
  end

  // next state and divider sequencing
  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    div_d   = div_q;
    bit_d   = bit_q;
    dig_d   = dig_q;
    big_d   = big_q;
    unique case (state_q)
      F_IDLE: begin
        if (accept) begin
          dvd_d = timeout_i;
          rem_d = '0;
          div_d = (interval_i == '0) ? IV_W'(1) : interval_i;
          bit_d = '0;
          big_d = 1'b0;
          if (cmd_e'(mode_i) == CMD_ADD) begin
            state_d = F_DIV;
          end else if (cmd_e'(mode_i) != CMD_NOP) begin
            state_d = F_PUSH;
          end
        end
      end
      F_DIV: begin
        dvd_d = qf;
        rem_d = rf;
        bit_d = bit_q + BW'(1);
        if (bit_q == BW'(TO_W - 1)) begin
          // split the delta into per-level digits, flag anything above them
          dig_d   = dext[XW-1:0];
          big_d   = |dext[XW +: TO_W];
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

endmodule

// ===== design/htw_back.sv =====
// Back end: owns the wheel position, entry pool and slot lists, carries out
// add, delete and tick commands and drives the result register. Uses
// htw_pkg and htw_ram.
module htw_back #(
  parameter int LEVELS      = 4,
  parameter int SLOTS       = 64,
  parameter int ENTRIES     = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  output logic                       q_ready_o,
  input  logic [htw_pkg::MODE_W+LEVELS*$clog2(SLOTS)+1+htw_pkg::HND_W-1:0] q_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [htw_pkg::HND_W-1:0]  result_handle_o,
  output logic [htw_pkg::ST_W-1:0]   status_o,
  output logic                       expired_o,
  output logic                       last_o,
  output htw_pkg::back_stat_t        stat_o
);
  import htw_pkg::*;

  localparam int DW  = $clog2(SLOTS);
  localparam int XW  = LEVELS * DW;
  localparam int QW  = MODE_W + XW + 1 + HND_W;
  localparam int EW  = $clog2(ENTRIES);
  localparam int PW  = $clog2(ENTRIES + 1);
  localparam int SA  = $clog2(LEVELS * SLOTS);
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int HB  = HANDLE_BITS;
  localparam int HCW = (HB > HND_W) ? HB : HND_W;
  localparam int MW  = XW + HB;
  localparam int CW  = $clog2(MAX_RESULTS + 1);
  localparam logic [PW-1:0] NIL = PW'(ENTRIES);

  typedef logic [LEVELS-1:0][DW-1:0] digits_t;

  // slot of the highest level whose digit is ahead of its position, else the level-0 slot of x
  function automatic logic [SA-1:0] slot_of(input digits_t x, input digits_t p);
    logic [SA-1:0] r;
    logic          hit;
    r   = SA'(x[0]);
    hit = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      if (!hit && (x[l] > p[l])) begin
        r   = SA'(l * SLOTS + int'(x[l]));
        hit = 1'b1;
      end
    end
    return r;
  endfunction

  back_state_e state_q, state_d;
  cmd_e             cmd_q, cmd_d;
  digits_t          dig_q, dig_d;
  logic             big_q, big_d;
  logic [HND_W-1:0] tgt_q, tgt_d;
  logic [HND_W-1:0] rh_q, rh_d;
  status_e          st_q, st_d;
  logic [SA-1:0]    clr_q, clr_d;
  logic [EW-1:0]    idx_q, idx_d;
  logic [EW-1:0]    ent_q, ent_d;
  logic [SA-1:0]    slot_q, slot_d;
  logic [PW-1:0]    cur_q, cur_d;
  logic [PW-1:0]    prev_q, prev_d;
  logic [LW-1:0]    lvl_q, lvl_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [HB-1:0]    hc_q, hc_d;
  digits_t          pos_q, pos_d;
  logic [ENTRIES-1:0] used_q, used_d;

  logic             out_valid_q;
  logic [HND_W-1:0] res_handle_q, ld_handle;
  status_e          res_status_q, ld_status;
  logic             res_expired_q, ld_expired;
  logic             res_last_q, ld_last;
  logic             load, can_load;

  // memory ports
  logic           slot_we;
  logic [SA-1:0]  slot_waddr, slot_raddr;
  logic [PW-1:0]  slot_wdata, slot_rdata;
  logic           next_we;
  logic [EW-1:0]  next_waddr;
  logic [PW-1:0]  next_wdata, next_rdata;
  logic           meta_we;
  logic [EW-1:0]  meta_raddr;
  logic [MW-1:0]  meta_wdata, meta_rdata;
  digits_t        meta_exp;
  logic [HB-1:0]  meta_hnd;

  // derived values
  digits_t        sum;
  logic           sum_over;
  logic [HB-1:0]  hc_inc, hc_next;
  logic [DW-1:0]  np;
  cmd_e           q_cmd;

  assign q_cmd    = cmd_e'(q_data_i[QW-1 -: MODE_W]);
  assign meta_exp = meta_rdata[MW-1 -: XW];
  assign meta_hnd = meta_rdata[HB-1:0];
  assign hc_inc   = hc_q + HB'(1);
  assign hc_next  = (hc_inc == '0) ? HB'(1) : hc_inc;
  assign np       = (pos_q[lvl_q] == DW'(SLOTS - 1)) ? '0 : pos_q[lvl_q] + DW'(1);
  assign can_load = !out_valid_q || out_ready_i;
  assign q_ready_o = (state_q == B_IDLE);

  assign meta_raddr = (cmd_q == CMD_DEL) ? idx_q : cur_q[EW-1:0];

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = res_handle_q;
  assign status_o        = res_status_q;
  assign expired_o       = res_expired_q;
  assign last_o          = res_last_q;
  assign stat_o.init_done = (state_q != B_CLR);
  assign stat_o.busy      = (state_q != B_CLR) && (state_q != B_IDLE);

  // expiry digits: position plus delta, with carry across levels
  always_comb begin : l_add
    logic [DW:0] s;
    logic        carry;
    carry = 1'b0;
    sum   = '0;
    for (int l = 0; l < LEVELS; l++) begin
      s = {1'b0, pos_q[l]} + {1'b0, dig_q[l]} + (DW+1)'(carry);
      if (s >= (DW+1)'(SLOTS)) begin
        s     = s - (DW+1)'(SLOTS);
        carry = 1'b1;
      end else begin
        carry = 1'b0;
      end
      sum[l] = s[DW-1:0];
    end
    sum_over = carry;
  end

  htw_ram #(.WIDTH(PW), .DEPTH(LEVELS * SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  htw_ram #(.WIDTH(PW), .DEPTH(ENTRIES)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (cur_q[EW-1:0]),
    .rdata_o (next_rdata)
  );

  htw_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (ent_q),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_q       <= '0;
      pos_q       <= '0;
      used_q      <= '0;
      hc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pos_q   <= pos_d;
      used_q  <= used_d;
      hc_q    <= hc_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    dig_q  <= dig_d;
    big_q  <= big_d;
    tgt_q  <= tgt_d;
    rh_q   <= rh_d;
    st_q   <= st_d;
    idx_q  <= idx_d;
    ent_q  <= ent_d;
    slot_q <= slot_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    lvl_q  <= lvl_d;
    cnt_q  <= cnt_d;
    if (load) begin
      res_handle_q  <= ld_handle;
      res_status_q  <= ld_status;
      res_expired_q <= ld_expired;
      res_last_q    <= ld_last;
    end
  end

  // command sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    dig_d   = dig_q;
    big_d   = big_q;
    tgt_d   = tgt_q;
    rh_d    = rh_q;
    st_d    = st_q;
    clr_d   = clr_q;
    idx_d   = idx_q;
    ent_d   = ent_q;
    slot_d  = slot_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    lvl_d   = lvl_q;
    cnt_d   = cnt_q;
    hc_d    = hc_q;
    pos_d   = pos_q;
    used_d  = used_q;

    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wdata = NIL;
    slot_raddr = slot_q;
    next_we    = 1'b0;
    next_waddr = ent_q;
    next_wdata = slot_rdata;
    meta_we    = 1'b0;
    meta_wdata = {sum, hc_q};

    load       = 1'b0;
    ld_handle  = rh_q;
    ld_status  = st_q;
    ld_expired = 1'b0;
    ld_last    = 1'b1;

    unique case (state_q)
      // sweep every slot head to empty after reset
      B_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        clr_d      = clr_q + SA'(1);
        if (clr_q == SA'(LEVELS * SLOTS - 1)) state_d = B_IDLE;
      end
      B_IDLE: begin
        if (q_valid_i) begin
          cmd_d = q_cmd;
          dig_d = q_data_i[QW-MODE_W-1 -: XW];
          big_d = q_data_i[HND_W];
          tgt_d = q_data_i[HND_W-1:0];
          rh_d  = q_data_i[HND_W-1:0];
          idx_d = '0;
          lvl_d = '0;
          case (q_cmd)
            CMD_ADD:  state_d = A_SCAN;
            CMD_DEL:  state_d = D_SCAN;
            CMD_TICK: state_d = T_ADV;
            default:  state_d = B_IDLE;
          endcase
        end
      end
      // single-beat result for add and delete
      B_RES: begin
        if (can_load) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      // find the lowest free entry, then check the span
      A_SCAN: begin
        if (!used_q[idx_q]) begin
          ent_d = idx_q;
          if (big_q || sum_over) begin
            rh_d    = '0;
            st_d    = ST_BEYOND;
            state_d = B_RES;
          end else begin
            hc_d          = hc_next;
            used_d[idx_q] = 1'b1;
            slot_d        = slot_of(sum, pos_q);
            slot_raddr    = slot_of(sum, pos_q);
            rh_d          = HND_W'(hc_next);
            st_d          = ST_OK;
            state_d       = A_LINK;
          end
        end else if (idx_q == EW'(ENTRIES - 1)) begin
          rh_d    = '0;
          st_d    = ST_NO_ENTRY;
          state_d = B_RES;
        end else begin
          idx_d = idx_q + EW'(1);
        end
      end
      // push the new entry at the slot head
      A_LINK: begin
        meta_we    = 1'b1;
        next_we    = 1'b1;
        next_wdata = slot_rdata;
        slot_we    = 1'b1;
        slot_wdata = PW'(ent_q);
        state_d    = B_RES;
      end
      // look up the lowest used entry with the target handle
      D_SCAN: begin
        st_d = ST_NOT_FOUND;
        if (used_q[idx_q]) begin
          state_d = D_CHK;
        end else if (idx_q == EW'(ENTRIES - 1)) begin
          state_d = B_RES;
        end else begin
          idx_d = idx_q + EW'(1);
        end
      end
      D_CHK: begin
        if (HCW'(meta_hnd) == HCW'(tgt_q)) begin
          ent_d      = idx_q;
          slot_d     = slot_of(meta_exp, pos_q);
          slot_raddr = slot_of(meta_exp, pos_q);
          state_d    = D_HEAD;
        end else if (idx_q == EW'(ENTRIES - 1)) begin
          state_d = B_RES;
        end else begin
          idx_d   = idx_q + EW'(1);
          state_d = D_SCAN;
        end
      end
      D_HEAD: begin
        cur_d   = slot_rdata;
        prev_d  = NIL;
        state_d = D_WALK;
      end
      D_WALK: begin
        if (cur_q == NIL) begin
          state_d = B_RES;
        end else begin
          state_d = D_STEP;
        end
      end
      // unlink on a match, otherwise advance along the chain
      D_STEP: begin
        if (cur_q == PW'(ent_q)) begin
          if (prev_q == NIL) begin
            slot_we    = 1'b1;
            slot_wdata = next_rdata;
          end else begin
            // reuse the next-pointer port to patch the predecessor
            next_we    = 1'b1;
            next_waddr = prev_q[EW-1:0];
            next_wdata = next_rdata;
          end
          used_d[ent_q] = 1'b0;
          st_d          = ST_OK;
          state_d       = B_RES;
        end else begin
          prev_d  = cur_q;
          ent_d   = ent_q;
          cur_d   = next_rdata;
          state_d = D_WALK;
        end
      end
      // advance one level's position
      T_ADV: begin
        pos_d[lvl_q] = np;
        if (lvl_q != '0) begin
          slot_d     = SA'(int'(lvl_q) * SLOTS + int'(np));
          slot_raddr = SA'(int'(lvl_q) * SLOTS + int'(np));
          state_d    = T_CHEAD;
        end else begin
          state_d = T_NEXT;
        end
      end
      T_NEXT: begin
        if ((pos_q[lvl_q] != '0) || (lvl_q == LW'(LEVELS - 1))) begin
          state_d = T_EXP0;
        end else begin
          lvl_d   = lvl_q + LW'(1);
          state_d = T_ADV;
        end
      end
      // detach the slot that comes due and re-place its entries
      T_CHEAD: begin
        cur_d   = slot_rdata;
        slot_we = 1'b1;
        state_d = T_CWALK;
      end
      T_CWALK: begin
        ent_d = cur_q[EW-1:0];
        if (cur_q == NIL) begin
          state_d = T_NEXT;
        end else begin
          state_d = T_CREAD;
        end
      end
      T_CREAD: begin
        prev_d     = next_rdata;
        slot_d     = slot_of(meta_exp, pos_q);
        slot_raddr = slot_of(meta_exp, pos_q);
        state_d    = T_CLINK;
      end
      T_CLINK: begin
        next_we    = 1'b1;
        next_wdata = slot_rdata;
        slot_we    = 1'b1;
        slot_wdata = cur_q;
        cur_d      = prev_q;
        state_d    = T_CWALK;
      end
      // empty the current level-0 slot
      T_EXP0: begin
        slot_d     = SA'(pos_q[0]);
        slot_raddr = SA'(pos_q[0]);
        state_d    = T_EHEAD;
      end
      T_EHEAD: begin
        cur_d   = slot_rdata;
        slot_we = 1'b1;
        cnt_d   = '0;
        state_d = T_EWALK;
      end
      T_EWALK: begin
        if (cur_q == NIL) begin
          state_d = B_IDLE;
        end else begin
          state_d = T_EOUT;
        end
      end
      // report and free one expired entry; drop reports past the limit
      T_EOUT: begin
        if (cnt_q < CW'(MAX_RESULTS)) begin
          if (can_load) begin
            load       = 1'b1;
            ld_handle  = HND_W'(meta_hnd);
            ld_status  = ST_OK;
            ld_expired = 1'b1;
            ld_last    = (next_rdata == NIL) || (cnt_q == CW'(MAX_RESULTS - 1));
            used_d[cur_q[EW-1:0]] = 1'b0;
            cnt_d   = cnt_q + CW'(1);
            cur_d   = next_rdata;
            state_d = T_EWALK;
          end
        end else begin
          used_d[cur_q[EW-1:0]] = 1'b0;
          cur_d   = next_rdata;
          state_d = T_EWALK;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

endmodule

// ===== design/hierarchical_timer_wheel.sv =====
// Hierarchical timer wheel: LEVELS levels of SLOTS slots over a pool of
// ENTRIES timers; SLOTS must be a power of two. A command beat (add,
// delete, tick) is taken by a front end and queued for the back end, so a
// new beat can be taken while the previous one is still being carried out.
// An add first runs the front end's bit-serial divider (timeout by
// interval; the per-level digits are then bit slices of the quotient) and
// then the back end's free-entry scan, a link and the report; a delete
// scans the pool for the handle and then walks the slot list to unlink
// the entry; a tick advances level 0 and each higher level whose lower
// level wraps, re-places the entries of each newly reached upper slot and
// drains the level-0 slot, one result beat for each of up to MAX_RESULTS expired entries.
// Every step is bounded by the one-read, one-write slot, link and entry RAMs.
// After reset the slot heads are swept to empty, one per cycle; no command
// is taken during the sweep.
// Depends on htw_pkg, htw_front, htw_queue, htw_back and htw_ram.
module hierarchical_timer_wheel #(
  parameter int LEVELS      = 4,
  parameter int SLOTS       = 64,
  parameter int ENTRIES     = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [htw_pkg::IV_W-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [htw_pkg::MODE_W-1:0] mode_i,
  input  logic [htw_pkg::TO_W-1:0]   timeout_i,
  input  logic [htw_pkg::HND_W-1:0]  target_handle_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [htw_pkg::HND_W-1:0]  result_handle_o,
  output logic [htw_pkg::ST_W-1:0]   status_o,
  output logic                       expired_o,
  output logic                       last_o
);
  import htw_pkg::*;

  localparam int QW = MODE_W + LEVELS * $clog2(SLOTS) + 1 + HND_W;

  logic [IV_W-1:0] interval_q;
  logic            push_valid, push_ready, pop_valid, pop_ready;
  logic [QW-1:0]   push_data, pop_data;
  back_stat_t      bstat;

  // tick interval register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IV_RESET;
    end else if (cfg_we_i) begin
      interval_q <= cfg_wdata_i;
    end
  end

  htw_front #(.LEVELS(LEVELS), .SLOTS(SLOTS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .timeout_i    (timeout_i),
    .target_i     (target_handle_i),
    .interval_i   (interval_q),
    .bstat_i      (bstat),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  htw_queue #(.WIDTH(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  htw_back #(
    .LEVELS      (LEVELS),
    .SLOTS       (SLOTS),
    .ENTRIES     (ENTRIES),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (pop_valid),
    .q_ready_o       (pop_ready),
    .q_data_i        (pop_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_handle_o (result_handle_o),
    .status_o        (status_o),
    .expired_o       (expired_o),
    .last_o          (last_o),
    .stat_o          (bstat)
  );

`ifndef SYNTHESIS
  // no command is taken while the slot heads are still being swept
  a_ready_after_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> bstat.init_done)
    else $error("command taken during slot sweep");

  // a new result beat is only loaded while a command is being carried out
  a_result_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bstat.busy))
    else $error("result beat without an active command");

  // expiry beats carry status ok; add and delete beats close their command
  a_expired_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && expired_o |-> status_o == ST_OK)
    else $error("expired beat with error status");

  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !expired_o |-> last_o)
    else $error("single-beat result without last");
`endif

endmodule

// ===== tb/sv/htw_result_checker.sv =====
// Result checker for the hierarchical timer wheel: watches the command,
// result and register ports, predicts every result beat and compares it.
// Depends on htw_pkg for the command and status encodings.
module htw_result_checker #(
  parameter int LEVELS      = 4,
  parameter int SLOTS       = 64,
  parameter int ENTRIES     = 64,
  parameter int HANDLE_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [htw_pkg::IV_W-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [htw_pkg::MODE_W-1:0] mode_i,
  input  logic [htw_pkg::TO_W-1:0]   timeout_i,
  input  logic [htw_pkg::HND_W-1:0]  target_handle_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [htw_pkg::HND_W-1:0]  result_handle_i,
  input  logic [htw_pkg::ST_W-1:0]   status_i,
  input  logic                       expired_i,
  input  logic                       last_i,
  output int                         pending_o,
  output int                         fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import htw_pkg::*;

  localparam int NIL = ENTRIES;

  typedef struct {
    logic [HND_W-1:0] hnd;
    status_e          st;
    logic             exp;
    logic             lst;
  } wheel_result_t;

  // Shadow copy of the wheel
  longint          tmr_expiry [ENTRIES];
  int              tmr_handle [ENTRIES];
  int              tmr_next   [ENTRIES];
  bit              tmr_used   [ENTRIES];
  int              slot_first [LEVELS*SLOTS];
  int              lvl_pos    [LEVELS];
  longint          now_tick;
  int              last_handle;
  logic [IV_W-1:0] interval;
  wheel_result_t   due_q[$];
  int              fails;

  assign pending_o    = due_q.size();
  assign fail_count_o = fails;

  function automatic longint wheel_span();
    longint s;
    s = 1;
    for (int i = 0; i < LEVELS; i++) s = s * SLOTS;
    return s;
  endfunction

  function automatic int digit_of(longint x, int lvl);
    for (int i = 0; i < lvl; i++) x = x / SLOTS;
    return int'(x % SLOTS);
  endfunction

  function automatic int slot_for(longint expiry);
    int d;
    for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
      d = digit_of(expiry, lvl);
      if (d > lvl_pos[lvl]) return lvl * SLOTS + d;
    end
    return digit_of(expiry, 0);
  endfunction

  function automatic void link_timer(int e);
    int idx;
    idx = slot_for(tmr_expiry[e]);
    tmr_next[e] = slot_first[idx];
    slot_first[idx] = e;
  endfunction

  function automatic void push_result(int h, status_e st, bit ex);
    wheel_result_t r;
    r.hnd = h[HND_W-1:0];
    r.st  = st;
    r.exp = ex;
    r.lst = 1'b1;
    due_q.push_back(r);
  endfunction

  function automatic void wheel_add(logic [TO_W-1:0] to);
    longint iv, expiry;
    int e;
    iv = (interval == 0) ? 1 : interval;
    expiry = now_tick + ((to > iv) ? (longint'(to) / iv) : 1);
    e = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (!tmr_used[i] && e < 0) e = i;
    if (e < 0) begin
      push_result(0, ST_NO_ENTRY, 0);
    end else if (expiry >= wheel_span()) begin
      push_result(0, ST_BEYOND, 0);
    end else begin
      last_handle = (last_handle + 1) % (1 << HANDLE_BITS);
      if (last_handle == 0) last_handle = 1;
      tmr_used[e]   = 1;
      tmr_handle[e] = last_handle;
      tmr_expiry[e] = expiry;
      link_timer(e);
      push_result(last_handle, ST_OK, 0);
    end
  endfunction

  function automatic void wheel_delete(logic [HND_W-1:0] target);
    int e, idx, prev, cur, guard;
    e = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (e < 0 && tmr_used[i] && tmr_handle[i] == int'(target)) e = i;
    if (e < 0) begin
      push_result(target, ST_NOT_FOUND, 0);
      return;
    end
    idx = slot_for(tmr_expiry[e]);
    prev = NIL;
    cur = slot_first[idx];
    guard = 0;
    while (cur < ENTRIES && guard < ENTRIES) begin
      if (cur == e) begin
        if (prev == NIL) slot_first[idx] = tmr_next[cur];
        else tmr_next[prev] = tmr_next[cur];
        tmr_used[e] = 0;
        push_result(target, ST_OK, 0);
        return;
      end
      prev = cur;
      cur = tmr_next[cur];
      guard++;
    end
    push_result(target, ST_NOT_FOUND, 0);
  endfunction

  function automatic void wheel_tick();
    int e, n, guard, idx, nxt;
    now_tick++;
    if (now_tick >= wheel_span()) now_tick = 0;
    // Advance positions and re-place the newly reached upper slots
    for (int lvl = 0; lvl < LEVELS; lvl++) begin
      lvl_pos[lvl]++;
      if (lvl_pos[lvl] >= SLOTS) lvl_pos[lvl] = 0;
      if (lvl > 0) begin
        idx = lvl * SLOTS + lvl_pos[lvl];
        e = slot_first[idx];
        slot_first[idx] = NIL;
        guard = 0;
        while (e < ENTRIES && guard < ENTRIES) begin
          nxt = tmr_next[e];
          link_timer(e);
          e = nxt;
          guard++;
        end
      end
      if (lvl_pos[lvl] != 0) break;
    end
    // Drain the current level-0 slot
    e = slot_first[lvl_pos[0]];
    slot_first[lvl_pos[0]] = NIL;
    n = 0;
    guard = 0;
    while (e < ENTRIES && guard < ENTRIES) begin
      if (n < MAX_RESULTS) begin
        push_result(tmr_handle[e], ST_OK, 1);
        due_q[due_q.size()-1].lst = 1'b0;
        n++;
      end
      tmr_used[e] = 0;
      e = tmr_next[e];
      guard++;
    end
    if (n > 0) due_q[due_q.size()-1].lst = 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    wheel_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        tmr_used[i] = 0;
        tmr_next[i] = NIL;
        tmr_handle[i] = 0;
        tmr_expiry[i] = 0;
      end
      for (int i = 0; i < LEVELS*SLOTS; i++) slot_first[i] = NIL;
      for (int i = 0; i < LEVELS; i++) lvl_pos[i] = 0;
      now_tick = 0;
      last_handle = 0;
      interval = IV_RESET;
      due_q.delete();
      fails = 0;
    end else begin
      // Check the result beat against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          $error("unexpected result beat: handle %0d", result_handle_i);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (result_handle_i !== want.hnd) begin
            $error("result_handle: expected %0d, got %0d", want.hnd, result_handle_i);
            fails++;
          end
          if (status_i !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status_i);
            fails++;
          end
          if (expired_i !== want.exp) begin
            $error("expired: expected %0d, got %0d", want.exp, expired_i);
            fails++;
          end
          if (last_i !== want.lst) begin
            $error("last: expected %0d, got %0d", want.lst, last_i);
            fails++;
          end
        end
      end
      // Predict the command beat
      if (in_valid_i && in_ready_i) begin
        case (cmd_e'(mode_i))
          CMD_ADD:  wheel_add(timeout_i);
          CMD_DEL:  wheel_delete(target_handle_i);
          CMD_TICK: wheel_tick();
          default: ;
        endcase
      end
      if (cfg_we_i) interval = cfg_wdata_i;
    end
  end

endmodule

// ===== tb/sv/hierarchical_timer_wheel_tb.sv =====
// Testbench top for the hierarchical timer wheel: drives commands, register
// writes and result back-pressure, and gives the verdict.
// Depends on htw_pkg, hierarchical_timer_wheel and htw_result_checker.
module hierarchical_timer_wheel_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htw_pkg::*;

  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 6000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [IV_W-1:0]   cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [MODE_W-1:0] mode_i = CMD_NOP;
  logic [TO_W-1:0]   timeout_i = '0;
  logic [HND_W-1:0]  target_handle_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [HND_W-1:0]  result_handle_o;
  logic [ST_W-1:0]   status_o;
  logic              expired_o;
  logic              last_o;
  int                pending;
  int                fail_count;

  bit                calm = 1'b0;
  int                rx_hold = 0;
  int                handles_issued = 0;
  int                idle_cycles = 0;
  logic [IV_W-1:0]   cur_iv = IV_RESET;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  hierarchical_timer_wheel dut (.*);

  htw_result_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .timeout_i, .target_handle_i,
    .out_valid_i(out_valid_o), .out_ready_i, .result_handle_i(result_handle_o),
    .status_i(status_o), .expired_i(expired_o), .last_i(last_o),
    .pending_o(pending), .fail_count_o(fail_count)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  // Result back-pressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i = 1'b0;
    end else if (rx_hold > 0) begin
      out_ready_i = 1'b0;
      rx_hold--;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      out_ready_i = 1'b0;
      rx_hold = gap_len();
    end else begin
      out_ready_i = 1'b1;
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("hierarchical_timer_wheel_tb failed");
      $finish;
    end
  end

  // Send one command beat; entered and left at a falling edge
  task automatic send(cmd_e m, logic [TO_W-1:0] to, logic [HND_W-1:0] h);
    int n;
    n = gap_len();
    repeat (n) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    mode_i = m;
    timeout_i = to;
    target_handle_i = h;
    while (!in_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    if (m == CMD_ADD) handles_issued++;
  endtask

  // Hold off until every expected result is in and the block has settled
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_interval(logic [IV_W-1:0] v);
    settle();
    cfg_we_i = 1'b1;
    cfg_wdata_i = v;
    cur_iv = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_cmd();
    int r, k;
    logic [TO_W-1:0] to;
    logic [HND_W-1:0] h;
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 99);
    if (k < 70) to = (cur_iv + 1) * $urandom_range(0, 80) + $urandom_range(0, cur_iv);
    else if (k < 95) to = (cur_iv + 1) * $urandom_range(0, 5000);
    else to = $urandom;
    if ($urandom_range(0, 9) == 0) h = $urandom;
    else h = $urandom_range(0, handles_issued + 1);
    if (r < 40) send(CMD_ADD, to, h);
    else if (r < 60) send(CMD_DEL, to, h);
    else if (r < 95) send(CMD_TICK, to, h);
    else send(CMD_NOP, to, h);
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: timeout extremes, interval boundaries, deletes, no-op, ticks
    send(CMD_ADD, 32'd0, 16'd0);
    send(CMD_ADD, 32'd1000, 16'd0);
    send(CMD_ADD, 32'd1001, 16'd0);
    send(CMD_ADD, 32'd2000, 16'd0);
    send(CMD_ADD, 32'hFFFF_FFFF, 16'd0);
    send(CMD_ADD, 32'd70_000, 16'd0);
    send(CMD_DEL, 32'd0, 16'd5);
    send(CMD_DEL, 32'd0, 16'd5);
    send(CMD_DEL, 32'hFFFF_FFFF, 16'hFFFF);
    send(CMD_DEL, 32'd0, 16'd0);
    send(CMD_DEL, 32'd0, 16'd6);
    send(CMD_NOP, 32'hFFFF_FFFF, 16'hFFFF);
    send(CMD_TICK, 32'd0, 16'd0);
    send(CMD_TICK, 32'd0, 16'd0);
    send(CMD_TICK, 32'd0, 16'd0);

    // Smallest interval: beyond-span and last in-span expiries
    write_interval(16'd1);
    send(CMD_ADD, 32'hFFFF_FFFF, 16'd0);
    send(CMD_ADD, 32'd16_777_210, 16'd0);
    send(CMD_ADD, 32'd16_777_300, 16'd0);
    send(CMD_DEL, 32'd0, 16'd7);
    // Zero interval acts as one
    write_interval(16'd0);
    send(CMD_ADD, 32'd3, 16'd0);
    send(CMD_ADD, 32'd1, 16'd0);

    // Fill the pool past capacity, then tick through a level-0 wrap
    write_interval(16'd1);
    calm = 1'b1;
    repeat (63) send(CMD_ADD, $urandom_range(0, 200), 16'd0);
    calm = 1'b0;
    repeat (3) send(CMD_DEL, 32'd0, $urandom_range(1, handles_issued));
    repeat (61) send(CMD_TICK, 32'd0, 16'd0);

    // Largest interval with random traffic
    write_interval(16'hFFFF);
    repeat (4) random_cmd();

    settle();
    if (fail_count == 0) begin
      $display("hierarchical_timer_wheel_tb passed");
    end else begin
      $display("hierarchical_timer_wheel_tb failed");
    end
    $finish;
  end

endmodule
